### design/scld_pkg.sv
`default_nettype none

package scld_pkg;

	// Result codes reported with every item
	typedef enum logic [2:0] {
		EV_NONE     = 3'd0,
		EV_APPLIED  = 3'd1,
		EV_NO_COLON = 3'd2,
		EV_UNKNOWN  = 3'd3,
		EV_REJECTED = 3'd4
	} event_t;

	// Lock motor modes
	typedef enum logic [1:0] {
		LOCK_IDLE      = 2'd0,
		LOCK_LOCKING   = 2'd1,
		LOCK_UNLOCKING = 2'd2
	} lock_mode_t;

	// Input kinds carried in tuser
	localparam logic OP_BYTE = 1'b0;
	localparam logic OP_TICK = 1'b1;

	// Special characters
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_VT    = 8'h0B;
	localparam logic [7:0] CH_FF    = 8'h0C;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_ONE   = 8'h31;
	localparam logic [7:0] CH_NINE  = 8'h39;

	// Key table: bit 0 contactor, bit 1 connector lock, bit 2 state C.
	// Each key is held as ASCII codes with its first character in the highest byte.
	localparam int NUM_KEYS = 3;
	localparam int KEY_TEXT_W = 18 * 8;
	localparam logic [KEY_TEXT_W-1:0] KEY_TEXT [NUM_KEYS] = '{
		KEY_TEXT_W'(104'h73_65_74_5f_63_6f_6e_74_61_63_74_6f_72),
		KEY_TEXT_W'(144'h73_65_74_5f_63_6f_6e_6e_65_63_74_6f_72_5f_6c_6f_63_6b),
		KEY_TEXT_W'(88'h73_65_74_5f_73_74_61_74_65_5f_63)
	};
	localparam logic [4:0] KEY_LEN [NUM_KEYS] = '{5'd13, 5'd18, 5'd11};

	localparam logic [15:0] LOCK_TIMEOUT_RESET = 16'd400;

	// Outcome of a completed line, handed from the parser to the pin logic
	typedef struct packed {
		event_t              ev;
		logic                cmd;
		logic [NUM_KEYS-1:0] keys;
	} line_res_t;

	// True when the character at position pos is the next character of key k.
	// The text is right-justified, so character pos sits at len-1-pos.
	function automatic logic key_hit(input int k, input logic [4:0] pos,
			input logic [7:0] c);
		logic hit;
		hit = 1'b0;
		if (pos < KEY_LEN[k]) begin
			hit = (KEY_TEXT[k][8 * (int'(KEY_LEN[k]) - 1 - int'(pos)) +: 8] == c);
		end
		return hit;
	endfunction

endpackage

`default_nettype wire

### design/scld_line_parser.sv
`default_nettype none

module scld_line_parser #(
	parameter int LINE_LIMIT = 42,
	parameter int KEY_LIMIT  = 32
) (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire                     en,
	input  wire [7:0]               rx_byte,
	output scld_pkg::line_res_t     res
);

	localparam int LW = (LINE_LIMIT > 2) ? $clog2(LINE_LIMIT) : 1;

	typedef enum logic [1:0] {
		PH_SPACE  = 2'd0,
		PH_DIGITS = 2'd1,
		PH_DONE   = 2'd3
	} phase_t;

	typedef enum logic [1:0] {
		CL_ZERO  = 2'd0,
		CL_ONE   = 2'd1,
		CL_OTHER = 2'd2
	} class_t;

	logic [LW-1:0]                 len_q, len_d;
	logic [scld_pkg::NUM_KEYS-1:0] keys_q, keys_d;
	logic                          colon_q, colon_d;
	phase_t                        phase_q, phase_d;
	class_t                        class_q, class_d;
	logic                          neg_q, neg_d;

	logic       is_digit;
	logic       is_space;
	logic [4:0] key_pos;
	logic       room;

	assign is_digit = (rx_byte >= scld_pkg::CH_ZERO) && (rx_byte <= scld_pkg::CH_NINE);
	assign is_space = (rx_byte == scld_pkg::CH_SPACE) || (rx_byte == scld_pkg::CH_TAB) ||
		(rx_byte == scld_pkg::CH_VT) || (rx_byte == scld_pkg::CH_FF);
	assign key_pos  = 5'(len_q);
	assign room     = ((LW+1)'(len_q) + (LW+1)'(1)) < (LW+1)'(LINE_LIMIT);

	// Next line state and the outcome of a line end
	always_comb begin
		len_d    = len_q;
		keys_d   = keys_q;
		colon_d  = colon_q;
		phase_d  = phase_q;
		class_d  = class_q;
		neg_d    = neg_q;
		res.ev   = scld_pkg::EV_NONE;
		res.cmd  = (class_q == CL_ONE);
		res.keys = keys_q;

		if (rx_byte == scld_pkg::CH_CR) begin
			// carriage return is ignored
		end else if (rx_byte == scld_pkg::CH_LF) begin
			if (len_q != '0) begin
				if (!colon_q) begin
					res.ev = scld_pkg::EV_NO_COLON;
				end else if (keys_q == '0) begin
					res.ev = scld_pkg::EV_UNKNOWN;
				end else if (class_q == CL_OTHER || (class_q == CL_ONE && neg_q)) begin
					res.ev = scld_pkg::EV_REJECTED;
				end else begin
					res.ev = scld_pkg::EV_APPLIED;
				end
				len_d   = '0;
				keys_d  = '1;
				colon_d = 1'b0;
				phase_d = PH_SPACE;
				class_d = CL_ZERO;
				neg_d   = 1'b0;
			end
		end else if (room) begin
			if (colon_q) begin
				// Value characters, read as atoi would
				if (phase_q != PH_DONE) begin
					if (is_digit) begin
						if (class_q == CL_ZERO) begin
							if (rx_byte == scld_pkg::CH_ZERO) begin
								class_d = CL_ZERO;
							end else if (rx_byte == scld_pkg::CH_ONE) begin
								class_d = CL_ONE;
							end else begin
								class_d = CL_OTHER;
							end
						end else begin
							class_d = CL_OTHER;
						end
						phase_d = PH_DIGITS;
					end else if (phase_q == PH_SPACE && is_space) begin
						// leading space is skipped
					end else if (phase_q == PH_SPACE &&
							(rx_byte == scld_pkg::CH_PLUS || rx_byte == scld_pkg::CH_MINUS)) begin
						neg_d   = (rx_byte == scld_pkg::CH_MINUS);
						phase_d = PH_DIGITS;
					end else begin
						phase_d = PH_DONE;
					end
				end
			end else if (rx_byte == scld_pkg::CH_COLON) begin
				// The key ends here: keep only keys of exactly this length, and none at KEY_LIMIT or more
				colon_d = 1'b1;
				for (int k = 0; k < scld_pkg::NUM_KEYS; k++) begin
					if (32'(len_q) != 32'(scld_pkg::KEY_LEN[k])) begin
						keys_d[k] = 1'b0;
					end
				end
				if (32'(len_q) >= 32'(KEY_LIMIT)) begin
					keys_d = '0;
				end
			end else begin
				// Key characters: drop every key that no longer matches
				for (int k = 0; k < scld_pkg::NUM_KEYS; k++) begin
					if (!((32'(len_q) < 32'(scld_pkg::KEY_LEN[k])) &&
							scld_pkg::key_hit(k, key_pos, rx_byte))) begin
						keys_d[k] = 1'b0;
					end
				end
			end
			len_d = len_q + LW'(1);
		end else begin
			// Overflow: the byte is dropped and the line starts again
			len_d   = '0;
			keys_d  = '1;
			colon_d = 1'b0;
			phase_d = PH_SPACE;
			class_d = CL_ZERO;
			neg_d   = 1'b0;
		end
	end

	// Line state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q   <= '0;
			keys_q  <= '1;
			colon_q <= 1'b0;
			phase_q <= PH_SPACE;
			class_q <= CL_ZERO;
			neg_q   <= 1'b0;
		end else if (en) begin
			len_q   <= len_d;
			keys_q  <= keys_d;
			colon_q <= colon_d;
			phase_q <= phase_d;
			class_q <= class_d;
			neg_q   <= neg_d;
		end
	end

endmodule

`default_nettype wire

### design/serial_command_line_decoder_core.sv
`default_nettype none

// Channel     Direction  Handshake                      Payload
// s_axis      in         s_axis_tvalid / s_axis_tready  tdata: rx_byte; tuser: op
// m_axis      out        m_axis_tvalid / m_axis_tready  tdata: pins, lock mode, event
// cfg         in         cfg_valid / cfg_ready          cfg_data: lock timeout in ticks
//
// Every item gives one result item: it passes from the input register through the decode
// logic into the result register; a stall on the output can keep it in the input register.
// One item per cycle is sustained while m_axis_tready is high; a stall on the output
// holds both registers and drops s_axis_tready only when both are full.
// Reset leaves the relay pin high, the other pins low, the lock idle and the timeout 400.
// cfg_ready is always high.

module serial_command_line_decoder_core #(
	parameter int LINE_LIMIT = 42,
	parameter int KEY_LIMIT  = 32
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_axis_tvalid,
	output logic        s_axis_tready,
	input  wire  [7:0]  s_axis_tdata,   // [7:0] rx_byte
	input  wire  [0:0]  s_axis_tuser,   // [0] op
	output logic        m_axis_tvalid,
	input  wire         m_axis_tready,
	output logic [15:0] m_axis_tdata,   // [0] relay_pin, [1] motor_a_pin, [2] motor_b_pin,
	                                    // [3] state_c_pin, [5:4] lock_mode, [8:6] event_res,
	                                    // [15:9] zero
	input  wire         cfg_valid,
	output logic        cfg_ready,
	input  wire  [15:0] cfg_data
);

	// Input register
	logic       valid_s1;
	logic       op_s1;
	logic [7:0] byte_s1;

	logic adv;
	logic out_free;

	// Controller state
	logic [15:0]          timeout_q;
	logic [15:0]          elapsed_q;
	scld_pkg::lock_mode_t mode_q;
	logic                 relay_q, mot_a_q, mot_b_q, state_c_q;

	// Next values
	logic [15:0]          elapsed_d;
	scld_pkg::lock_mode_t mode_d;
	logic                 relay_d, mot_a_d, mot_b_d, state_c_d;
	scld_pkg::event_t     ev_d;

	scld_pkg::line_res_t line_res;

	assign out_free      = !m_axis_tvalid || m_axis_tready;
	assign adv           = valid_s1 && out_free;
	assign s_axis_tready = !valid_s1 || out_free;
	assign cfg_ready     = 1'b1;

	// Line gathering and key/value decoding
	scld_line_parser #(
		.LINE_LIMIT (LINE_LIMIT),
		.KEY_LIMIT  (KEY_LIMIT)
	) u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (adv && (op_s1 == scld_pkg::OP_BYTE)),
		.rx_byte (byte_s1),
		.res     (line_res)
	);

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			op_s1   <= s_axis_tuser[0];
			byte_s1 <= s_axis_tdata;
		end
	end

	// Timer and pin updates
	always_comb begin
		elapsed_d = elapsed_q;
		mode_d    = mode_q;
		relay_d   = relay_q;
		mot_a_d   = mot_a_q;
		mot_b_d   = mot_b_q;
		state_c_d = state_c_q;
		ev_d      = scld_pkg::EV_NONE;

		if (op_s1 == scld_pkg::OP_TICK) begin
			if (elapsed_q != 16'hFFFF) begin
				elapsed_d = elapsed_q + 16'd1;
			end
			if (elapsed_d >= timeout_q) begin
				mot_a_d = 1'b0;
				mot_b_d = 1'b0;
				mode_d  = scld_pkg::LOCK_IDLE;
			end
		end else begin
			ev_d = line_res.ev;
			if (line_res.ev == scld_pkg::EV_APPLIED) begin
				if (line_res.keys[0]) begin
					relay_d = !line_res.cmd;
				end else if (line_res.keys[1]) begin
					mot_a_d   = !line_res.cmd;
					mot_b_d   = line_res.cmd;
					mode_d    = line_res.cmd ? scld_pkg::LOCK_LOCKING : scld_pkg::LOCK_UNLOCKING;
					elapsed_d = '0;
				end else begin
					state_c_d = line_res.cmd;
				end
			end
		end
	end

	// Controller state and configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= scld_pkg::LOCK_TIMEOUT_RESET;
			elapsed_q <= '0;
			mode_q    <= scld_pkg::LOCK_IDLE;
			relay_q   <= 1'b1;
			mot_a_q   <= 1'b0;
			mot_b_q   <= 1'b0;
			state_c_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				timeout_q <= cfg_data;
			end
			if (adv) begin
				elapsed_q <= elapsed_d;
				mode_q    <= mode_d;
				relay_q   <= relay_d;
				mot_a_q   <= mot_a_d;
				mot_b_q   <= mot_b_d;
				state_c_q <= state_c_d;
			end
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tvalid <= 1'b0;
		end else if (out_free) begin
			m_axis_tvalid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			m_axis_tdata <= {7'd0, ev_d, mode_d, state_c_d, mot_b_d, mot_a_d, relay_d};
		end
	end

endmodule

`default_nettype wire

### tb/serial_command_line_decoder_core_test.sv
`timescale 1ns / 100ps

module serial_command_line_decoder_core_test;
	import scld_pkg::*;

	localparam int LINE_LIMIT = 42;
	localparam int KEY_LIMIT = 32;
	localparam int VALUE_FORMS = 21;
	localparam int CYCLE_LIMIT = 1500000;

	typedef enum logic [1:0] {
		PH_SPACE,
		PH_DIGITS,
		PH_DONE
	} value_phase_t;

	typedef enum logic [1:0] {
		CLASS_ZERO,
		CLASS_ONE,
		CLASS_OTHER
	} value_class_t;

	// Patterns the result side uses to hold off items
	typedef enum logic [1:0] {
		RX_ALWAYS,
		RX_RANDOM,
		RX_PERIODIC,
		RX_HEAVY
	} rx_pattern_t;

	typedef struct packed {
		logic       op;
		logic [7:0] rx_byte;
	} serial_item_t;

	typedef struct packed {
		logic       relay;
		logic       mot_a;
		logic       mot_b;
		logic       state_c;
		lock_mode_t mode;
		event_t     ev;
	} pin_state_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata = 8'h00;   // [7:0] rx_byte
	logic [0:0]  s_axis_tuser = 1'b0;    // [0] op
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [15:0] m_axis_tdata;           // [0] relay, [1] motor A, [2] motor B, [3] state C,
	                                     // [5:4] lock mode, [8:6] event
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [15:0] cfg_data = 16'h0000;

	serial_command_line_decoder_core u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data)
	);

	// Items waiting to be sent and pin states waiting to be seen
	serial_item_t pending_items[$];
	pin_state_t   expected_pins[$];
	int           items_queued = 0;
	int           mismatch_count = 0;
	int           cycle_count = 0;
	int           burst_left = 1;
	int           gap_left = 0;
	rx_pattern_t  rx_pattern = RX_ALWAYS;
	int           rx_span = 0;

	// Shadow of the decoder state
	int           line_len;
	logic [2:0]   keys_left;
	logic         colon_seen;
	value_phase_t val_phase;
	value_class_t val_class;
	logic         val_neg;
	lock_mode_t   lock_mode;
	logic [15:0]  lock_ticks;
	logic [15:0]  lock_timeout;
	logic         relay_pin;
	logic         mot_a_pin;
	logic         mot_b_pin;
	logic         state_c_pin;

	always #5 clk = ~clk;

	// Key text by table position: bit 0 contactor, bit 1 connector lock, bit 2 state C.
	// The text is spelt out as ASCII codes.
	function automatic string key_name(input int k);
		case (k)
			0: return $sformatf("%s", 104'h73_65_74_5f_63_6f_6e_74_61_63_74_6f_72);
			1: return $sformatf("%s",
				144'h73_65_74_5f_63_6f_6e_6e_65_63_74_6f_72_5f_6c_6f_63_6b);
			default: return $sformatf("%s", 88'h73_65_74_5f_73_74_61_74_65_5f_63);
		endcase
	endfunction

	function automatic string value_text(input int n);
		case (n)
			0: return "";
			1: return "0";
			2: return "1";
			3: return "2";
			4: return "9";
			5: return "01";
			6: return "10";
			7: return "00";
			8: return "-0";
			9: return "-1";
			10: return "+0";
			11: return "+1";
			12: return " 1";
			13: return "\011\013\014 0";
			14: return "- 1";
			15: return "+-1";
			16: return "1x";
			17: return "0:1";
			18: return "  -01";
			19: return "000000001";
			default: return "1 ";
		endcase
	endfunction

	function automatic void restart_line();
		line_len = 0;
		keys_left = 3'b111;
		colon_seen = 1'b0;
		val_phase = PH_SPACE;
		val_class = CLASS_ZERO;
		val_neg = 1'b0;
	endfunction

	// Advances the shadow state by one accepted item and returns the pins it should show.
	function automatic pin_state_t decode_item(input serial_item_t item);
		event_t     ev;
		logic       cmd;
		logic [7:0] ch;
		string      key;
		pin_state_t res;
		ev = EV_NONE;
		ch = item.rx_byte;
		if (item.op == OP_TICK) begin
			if (lock_ticks != 16'hFFFF)
				lock_ticks = lock_ticks + 16'd1;
			if (lock_ticks >= lock_timeout) begin
				mot_a_pin = 1'b0;
				mot_b_pin = 1'b0;
				lock_mode = LOCK_IDLE;
			end
		end else if (ch == CH_CR) begin
			// A carriage return leaves the line untouched.
		end else if (ch == CH_LF) begin
			if (line_len > 0) begin
				if (!colon_seen) begin
					ev = EV_NO_COLON;
				end else if (keys_left == 3'b000) begin
					ev = EV_UNKNOWN;
				end else if (val_class == CLASS_OTHER || (val_class == CLASS_ONE && val_neg)) begin
					ev = EV_REJECTED;
				end else begin
					cmd = (val_class == CLASS_ONE);
					ev = EV_APPLIED;
					if (keys_left[0]) begin
						relay_pin = !cmd;
					end else if (keys_left[1]) begin
						mot_a_pin = !cmd;
						mot_b_pin = cmd;
						if (cmd)
							lock_mode = LOCK_LOCKING;
						else
							lock_mode = LOCK_UNLOCKING;
						lock_ticks = 16'd0;
					end else begin
						state_c_pin = cmd;
					end
				end
				restart_line();
			end
		end else if (line_len + 1 < LINE_LIMIT) begin
			if (colon_seen) begin
				// Value read as atoi would: spaces, one sign, then digits.
				if (val_phase != PH_DONE) begin
					if (ch >= CH_ZERO && ch <= CH_NINE) begin
						if (val_class != CLASS_ZERO || (ch != CH_ZERO && ch != CH_ONE))
							val_class = CLASS_OTHER;
						else if (ch == CH_ONE)
							val_class = CLASS_ONE;
						val_phase = PH_DIGITS;
					end else if (val_phase == PH_SPACE && (ch == CH_SPACE || ch == CH_TAB ||
							ch == CH_VT || ch == CH_FF)) begin
						// Leading white space is skipped.
					end else if (val_phase == PH_SPACE && (ch == CH_PLUS || ch == CH_MINUS)) begin
						val_neg = (ch == CH_MINUS);
						val_phase = PH_DIGITS;
					end else begin
						val_phase = PH_DONE;
					end
				end
			end else if (ch == CH_COLON) begin
				colon_seen = 1'b1;
				for (int k = 0; k < NUM_KEYS; k++) begin
					key = key_name(k);
					if (line_len != key.len())
						keys_left[k] = 1'b0;
				end
				if (line_len >= KEY_LIMIT)
					keys_left = 3'b000;
			end else begin
				for (int k = 0; k < NUM_KEYS; k++) begin
					key = key_name(k);
					if (!(line_len < key.len() && key[line_len] == ch))
						keys_left[k] = 1'b0;
				end
			end
			line_len++;
		end else begin
			// The byte that would overflow is dropped and the line starts afresh.
			restart_line();
		end
		res.relay = relay_pin;
		res.mot_a = mot_a_pin;
		res.mot_b = mot_b_pin;
		res.state_c = state_c_pin;
		res.mode = lock_mode;
		res.ev = ev;
		return res;
	endfunction

	function automatic void check_field(input string name, input logic [2:0] want,
			input logic [2:0] got);
		if (got !== want) begin
			$display("%0t: %s expected %0d, got %0d", $time, name, want, got);
			mismatch_count++;
		end
	endfunction

	task automatic push_item(input logic op, input logic [7:0] data);
		serial_item_t item;
		item.op = op;
		item.rx_byte = data;
		pending_items.push_back(item);
		items_queued++;
	endtask

	task automatic push_char(input logic [7:0] ch);
		push_item(OP_BYTE, ch);
	endtask

	task automatic push_text(input string s);
		for (int i = 0; i < s.len(); i++)
			push_char(s[i]);
	endtask

	task automatic push_ticks(input int n);
		repeat (n) push_item(OP_TICK, 8'($urandom_range(0, 255)));
	endtask

	// One line of random content, mostly shaped like a command.
	task automatic push_random_line();
		int    kind;
		int    variant;
		int    n;
		int    bad;
		int    cut;
		string key;
		kind = $urandom_range(0, 99);
		if (kind < 70) begin
			// A command, now and then with a damaged, short or long key.
			key = key_name($urandom_range(0, NUM_KEYS - 1));
			variant = $urandom_range(0, 11);
			n = key.len();
			cut = (variant == 1) ? n - 1 : n;
			bad = (variant == 0) ? $urandom_range(0, n - 1) : n;
			for (int i = 0; i < cut; i++) begin
				if (i == bad)
					push_char(8'($urandom_range(8'h61, 8'h7A)));
				else
					push_char(key[i]);
			end
			if (variant == 2)
				push_char(8'h5F);
			if (variant == 3)
				push_ticks($urandom_range(1, 3));
			push_char(CH_COLON);
			if ($urandom_range(0, 3) == 0)
				push_ticks($urandom_range(1, 3));
			n = ($urandom_range(0, 2) == 0) ? $urandom_range(0, VALUE_FORMS - 1) :
				$urandom_range(1, 2);
			push_text(value_text(n));
			if ($urandom_range(0, 5) == 0)
				push_char(8'($urandom_range(0, 255)));
			if ($urandom_range(0, 3) == 0)
				push_char(CH_CR);
			push_char(CH_LF);
		end else if (kind < 78) begin
			// Keys around the key length limit, in lower-case letters.
			n = $urandom_range(KEY_LIMIT - 3, KEY_LIMIT + 8);
			repeat (n) push_char(8'($urandom_range(8'h61, 8'h7A)));
			push_text(":1\n");
		end else if (kind < 88) begin
			// Lines near or past the buffer length, sometimes followed straight by a command.
			n = ($urandom_range(0, 1) == 0) ? LINE_LIMIT :
				$urandom_range(LINE_LIMIT - 4, LINE_LIMIT + 8);
			repeat (n) push_char(8'($urandom_range(8'h20, 8'h7E)));
			if ($urandom_range(0, 1) == 0) begin
				push_char(CH_LF);
			end else begin
				push_text({key_name(2), ":"});
				push_char(8'($urandom_range(CH_ZERO, CH_ONE)));
				push_char(CH_LF);
			end
		end else begin
			repeat ($urandom_range(1, 12)) push_char(8'($urandom_range(0, 255)));
		end
	endtask

	task automatic run_random_phase(input int count);
		int first;
		first = items_queued;
		while (items_queued - first < count) begin
			push_random_line();
			case ($urandom_range(0, 9))
				5, 6, 7: push_ticks($urandom_range(1, 4));
				8: push_ticks($urandom_range(5, 30));
				9: push_ticks($urandom_range(30, 120));
				default: ;
			endcase
		end
	endtask

	// Waits until every item has gone through, then lets the pipeline drain.
	task automatic wait_idle();
		@(negedge clk);
		while (pending_items.size() != 0 || s_axis_tvalid || expected_pins.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_timeout(input logic [15:0] ticks);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= ticks;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		lock_timeout = ticks;
	endtask

	// Sender: items leave the queue in bursts with gaps between them.
	always @(posedge clk) begin : drive_items
		serial_item_t next_item;
		logic         next_valid;
		next_valid = s_axis_tvalid;
		if (s_axis_tvalid && s_axis_tready) begin
			expected_pins.push_back(decode_item({s_axis_tuser[0], s_axis_tdata}));
			next_valid = 1'b0;
		end
		if (!next_valid && arst_n) begin
			if (gap_left > 0) begin
				gap_left--;
			end else if (pending_items.size() > 0) begin
				next_item = pending_items.pop_front();
				s_axis_tdata <= next_item.rx_byte;
				s_axis_tuser <= next_item.op;
				next_valid = 1'b1;
				if (burst_left > 1) begin
					burst_left--;
				end else begin
					burst_left = $urandom_range(1, 32);
					gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 4);
				end
			end
		end
		s_axis_tvalid <= next_valid;
	end

	// Receiver: checks each result item and stalls on a pattern that changes now and then.
	always @(posedge clk) begin : watch_results
		pin_state_t want;
		logic       ready;
		if (m_axis_tvalid && m_axis_tready) begin
			if (expected_pins.size() == 0) begin
				$display("%0t: result item %h arrived with none expected", $time, m_axis_tdata);
				mismatch_count++;
			end else begin
				want = expected_pins.pop_front();
				check_field("relay_pin", 3'(want.relay), 3'(m_axis_tdata[0]));
				check_field("motor_a_pin", 3'(want.mot_a), 3'(m_axis_tdata[1]));
				check_field("motor_b_pin", 3'(want.mot_b), 3'(m_axis_tdata[2]));
				check_field("state_c_pin", 3'(want.state_c), 3'(m_axis_tdata[3]));
				check_field("lock_mode", 3'(want.mode), 3'(m_axis_tdata[5:4]));
				check_field("event_res", want.ev, m_axis_tdata[8:6]);
			end
		end
		if (rx_span == 0) begin
			rx_pattern = rx_pattern_t'($urandom_range(0, 3));
			rx_span = $urandom_range(16, 200);
		end else begin
			rx_span--;
		end
		case (rx_pattern)
			RX_ALWAYS: ready = 1'b1;
			RX_RANDOM: ready = ($urandom_range(0, 3) != 0);
			RX_PERIODIC: ready = ((cycle_count % 6) >= 2);
			default: ready = ($urandom_range(0, 1) == 0);
		endcase
		m_axis_tready <= ready;
	end

	// Watchdog against a hung run.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	initial begin
		lock_timeout = LOCK_TIMEOUT_RESET;
		restart_line();
		lock_mode = LOCK_IDLE;
		lock_ticks = 16'd0;
		relay_pin = 1'b1;
		mot_a_pin = 1'b0;
		mot_b_pin = 1'b0;
		state_c_pin = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// Short directed run: tick, empty line, carriage return, a command, odd bytes.
		push_item(OP_TICK, 8'hFF);
		push_char(CH_LF);
		push_char(CH_CR);
		push_text({key_name(2), ":1"});
		push_char(CH_CR);
		push_char(CH_LF);
		push_char(8'h00);
		push_char(8'hFF);
		push_char(CH_LF);

		// The lock motor keeps running for a few ticks under the timeout left by reset.
		push_text({key_name(1), ":1\n"});
		push_ticks(5);
		wait_idle();

		write_timeout(16'd1);
		run_random_phase(330);
		wait_idle();

		write_timeout(16'($urandom_range(2, 40)));
		run_random_phase(330);
		wait_idle();

		// Longest timeout: the motor keeps running through the ticks that follow.
		write_timeout(16'hFFFF);
		run_random_phase(330);
		push_text({key_name(1), ":0\n"});
		push_ticks(20);
		wait_idle();

		if (mismatch_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
